/* design/lcrs_pkg.sv */
// Shared types and constants of the lane center row scanner.
package lcrs_pkg;

    // Field widths fixed by the stream and register layout.
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 10;
    localparam int ROW_W    = 9;
    localparam int COUNT_W  = 11;
    localparam int ERR_W    = 11;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ROW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WHITE_MIN = 3'd4;

    // Register values after reset.
    localparam int RST_IMAGE_WIDTH    = 640;
    localparam int RST_IMAGE_HEIGHT   = 310;
    localparam int RST_TARGET_ROW     = 235;
    localparam int RST_STOP_ROW       = 245;
    localparam int RST_STOP_WHITE_MIN = 180;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_PIX,
        ST_LOAD_L,
        ST_DIV_L,
        ST_DIV_R,
        ST_ROW,
        ST_OUT
    } lcrs_state_t;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic pix_ready;
        logic load_left;
        logic div_step;
        logic row_done;
        logic out_try;
    } lcrs_ctrl_t;

endpackage

/* design/lane_center_row_scanner_top.sv */
// Lane center row scanner: pixel accumulation, shared row-end divider and frame result.
// Each pixel item is taken in one cycle while a row is in progress.
// The last pixel of a row starts an SW-bit division, SW = 2*clog2(MAX_WIDTH+1), in which
// one shared restoring divider forms the left mean and then the right mean, one bit a cycle.
// After the top row of a frame the result register is loaded, once it is empty or being read.
// rst_n is asynchronous and active low; it restores the register defaults and clears
// the counters, accumulators, stop flag and result valid.
module lane_center_row_scanner_top
    import lcrs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] pixel_white, [7:1] zero
    input  logic [0:0]           s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [10:0] lateral_error, [21:11] center_column,
                                            // [22] stop_seen, [23] zero
);

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = 2 * XW;
    localparam int CNW = $clog2(SW);
    localparam logic [CNW-1:0] DIV_LAST = CNW'(SW - 1);

    // Clamp a written width to the supported range.
    function automatic logic [XW-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        int unsigned t;
        t = 32'(v);
        if (t < 32'd2) t = 32'd2;
        if (t > 32'(MAX_WIDTH)) t = 32'(MAX_WIDTH);
        return t[XW-1:0];
    endfunction

    localparam logic [XW-1:0] RST_HALF = XW'((RST_IMAGE_WIDTH < MAX_WIDTH ?
                                              RST_IMAGE_WIDTH : MAX_WIDTH) / 2);

    // Configuration registers.
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    target_row_reg;
    logic [ROW_W-1:0]    stop_row_reg;
    logic [COUNT_W-1:0]  stop_min_reg;

    // Scan state.
    lcrs_state_t state_reg, state_next;
    lcrs_ctrl_t  ctrl;
    logic [XW-1:0]  col_reg;
    logic [YW-1:0]  row_reg;
    logic [XW-1:0]  split_reg;
    logic [SW-1:0]  lsum_reg, rsum_reg;
    logic [XW-1:0]  lcnt_reg, rcnt_reg;
    logic           lhit_reg, rhit_reg;
    logic [XW-1:0]  total_reg;
    logic [XW-1:0]  tc_reg;
    logic           stop_reg;

    // Shared divider.
    logic [XW-1:0]  rem_reg;
    logic [SW-1:0]  quo_reg;
    logic [XW-1:0]  dvs_reg;
    logic [CNW-1:0] cnt_reg;
    logic [XW-1:0]  lq_reg, rq_reg;

    // Result register.
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    // Effective geometry.
    logic [XW-1:0] w_eff, hw, w_m1;
    logic [YW-1:0] h_m1;
    int unsigned   h_int;

    always_comb
    begin
        w_eff = clamp_width(width_reg);
        hw    = w_eff >> 1;
        w_m1  = w_eff - XW'(1);
        h_int = 32'(height_reg);
        if (h_int < 32'd1) h_int = 32'd1;
        if (h_int > 32'(MAX_HEIGHT)) h_int = 32'(MAX_HEIGHT);
        h_m1  = h_int[YW-1:0] - YW'(1);
    end

    // Pixel accumulation with frame start clearing.
    logic           pix, fs, row_end;
    logic [XW-1:0]  col_b, split_b, x;
    logic [SW-1:0]  lsum_n, rsum_n;
    logic [XW-1:0]  lcnt_n, rcnt_n, total_n;
    logic           lhit_n, rhit_n;

    always_comb
    begin
        pix     = s_tdata[0];
        fs      = s_tuser[0];
        col_b   = fs ? '0 : col_reg;
        split_b = fs ? hw : split_reg;
        lsum_n  = fs ? '0 : lsum_reg;
        rsum_n  = fs ? '0 : rsum_reg;
        lcnt_n  = fs ? '0 : lcnt_reg;
        rcnt_n  = fs ? '0 : rcnt_reg;
        lhit_n  = fs ? 1'b0 : lhit_reg;
        rhit_n  = fs ? 1'b0 : rhit_reg;
        total_n = fs ? '0 : total_reg;
        x       = (col_b > w_m1) ? w_m1 : col_b;
        if (pix)
        begin
            total_n = total_n + XW'(1);
            if (x < split_b)
            begin
                lsum_n = lsum_n + SW'(x);
                lcnt_n = lcnt_n + XW'(1);
                if (({1'b0, x} + {1'b0, hw}) >= {1'b0, split_b}) lhit_n = 1'b1;
            end
            else
            begin
                rsum_n = rsum_n + SW'(x);
                rcnt_n = rcnt_n + XW'(1);
                if ({1'b0, x} < ({1'b0, split_b} + {1'b0, hw})) rhit_n = 1'b1;
            end
        end
        row_end = ({1'b0, x} + {{XW{1'b0}}, 1'b1}) >= {1'b0, w_eff};
    end

    // One restoring division step.
    logic [XW:0]   rem_sh, rem_sub;
    logic          ge;
    logic [XW-1:0] rem_new;
    logic [SW-1:0] quo_new;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[SW-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        rem_new = ge ? rem_sub[XW-1:0] : rem_sh[XW-1:0];
        quo_new = {quo_reg[SW-2:0], ge};
    end

    // Row end: edges, center and vertical position.
    logic [XW-1:0] lo, hi, left_e, right_e, mid;
    logic [XW:0]   sp_hw, mid_sum;
    logic [YW-1:0] y;
    logic          y_zero, stop_hit, target_hit;

    always_comb
    begin
        lo      = (split_reg > hw) ? split_reg - hw : '0;
        sp_hw   = {1'b0, split_reg} + {1'b0, hw};
        hi      = (sp_hw < {1'b0, w_eff}) ? sp_hw[XW-1:0] : w_eff;
        left_e  = lhit_reg ? lq_reg : lo;
        right_e = rhit_reg ? rq_reg : hi;
        mid_sum = {1'b0, left_e} + {1'b0, right_e};
        mid     = mid_sum[XW:1];
        if (mid > w_m1) mid = w_m1;
        y          = (row_reg < h_m1) ? h_m1 - row_reg : '0;
        y_zero     = (y == '0);
        stop_hit   = (32'(y) == 32'(stop_row_reg)) &&
                     (32'(total_reg) >= 32'(stop_min_reg));
        target_hit = (32'(y) == 32'(target_row_reg));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PIX:    if (s_tvalid && row_end) state_next = ST_LOAD_L;
            ST_LOAD_L: state_next = ST_DIV_L;
            ST_DIV_L:  if (cnt_reg == DIV_LAST) state_next = ST_DIV_R;
            ST_DIV_R:  if (cnt_reg == DIV_LAST) state_next = ST_ROW;
            ST_ROW:    state_next = y_zero ? ST_OUT : ST_PIX;
            ST_OUT:    if (!m_valid_reg || m_tready) state_next = ST_PIX;
            default:   state_next = ST_PIX;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_PIX:    ctrl.pix_ready = 1'b1;
            ST_LOAD_L: ctrl.load_left = 1'b1;
            ST_DIV_L:  ctrl.div_step  = 1'b1;
            ST_DIV_R:  ctrl.div_step  = 1'b1;
            ST_ROW:    ctrl.row_done  = 1'b1;
            ST_OUT:    ctrl.out_try   = !m_valid_reg || m_tready;
            default:   ctrl = '0;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PIX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_left)
        begin
            rem_reg <= '0;
            quo_reg <= lsum_reg;
            dvs_reg <= lcnt_reg;
            cnt_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            cnt_reg <= cnt_reg + CNW'(1);
            if (cnt_reg == DIV_LAST)
            begin
                if (state_reg == ST_DIV_L)
                begin
                    lq_reg  <= quo_new[XW-1:0];
                    rem_reg <= '0;
                    quo_reg <= rsum_reg;
                    dvs_reg <= rcnt_reg;
                    cnt_reg <= '0;
                end
                else
                begin
                    rq_reg <= quo_new[XW-1:0];
                end
            end
        end
    end

    // Scan state, result register and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_W'(RST_IMAGE_WIDTH);
            height_reg     <= HEIGHT_W'(RST_IMAGE_HEIGHT);
            target_row_reg <= ROW_W'(RST_TARGET_ROW);
            stop_row_reg   <= ROW_W'(RST_STOP_ROW);
            stop_min_reg   <= COUNT_W'(RST_STOP_WHITE_MIN);
            col_reg        <= '0;
            row_reg        <= '0;
            split_reg      <= RST_HALF;
            tc_reg         <= RST_HALF;
            lsum_reg       <= '0;
            rsum_reg       <= '0;
            lcnt_reg       <= '0;
            rcnt_reg       <= '0;
            lhit_reg       <= 1'b0;
            rhit_reg       <= 1'b0;
            total_reg      <= '0;
            stop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            // Pixel item taken.
            if (ctrl.pix_ready && s_tvalid)
            begin
                lsum_reg  <= lsum_n;
                rsum_reg  <= rsum_n;
                lcnt_reg  <= lcnt_n;
                rcnt_reg  <= rcnt_n;
                lhit_reg  <= lhit_n;
                rhit_reg  <= rhit_n;
                total_reg <= total_n;
                col_reg   <= row_end ? x : x + XW'(1);
                if (fs)
                begin
                    row_reg   <= '0;
                    split_reg <= hw;
                    tc_reg    <= hw;
                end
            end

            // Row finished: move the split and clear the accumulators.
            if (ctrl.row_done)
            begin
                if (stop_hit) stop_reg <= 1'b1;
                if (target_hit) tc_reg <= mid;
                split_reg <= mid;
                col_reg   <= '0;
                lsum_reg  <= '0;
                rsum_reg  <= '0;
                lcnt_reg  <= '0;
                rcnt_reg  <= '0;
                lhit_reg  <= 1'b0;
                rhit_reg  <= 1'b0;
                total_reg <= '0;
                if (!y_zero) row_reg <= row_reg + YW'(1);
            end

            // Frame result and restart of the frame.
            if (ctrl.out_try)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {1'b0, stop_reg, WIDTH_W'(tc_reg),
                                ERR_W'(32'(hw) - 32'(tc_reg))};
                row_reg     <= '0;
                split_reg   <= hw;
                tc_reg      <= hw;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        split_reg <= clamp_width(cfg_data) >> 1;
                        tc_reg    <= clamp_width(cfg_data) >> 1;
                    end
                    CFG_IMAGE_HEIGHT:   height_reg     <= cfg_data[HEIGHT_W-1:0];
                    CFG_TARGET_ROW:     target_row_reg <= cfg_data[ROW_W-1:0];
                    CFG_STOP_ROW:       stop_row_reg   <= cfg_data[ROW_W-1:0];
                    CFG_STOP_WHITE_MIN: stop_min_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    assign s_tready = ctrl.pix_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The last pixel of a row starts the divider sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && row_end) |=> (state_reg == ST_LOAD_L))
        else $error("row end did not start the divider");

    // The divider step count stays inside one division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_L || state_reg == ST_DIV_R) |-> (32'(cnt_reg) < 32'(SW)))
        else $error("divider step count out of range");

    // A new result appears only from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result valid rose outside the result state");

    // No pixel is taken while the divider is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> !s_tready)
        else $error("pixel ready during division");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the lane center row scanner: directed rows, random frames, frame predictor.
module tb;
    import lcrs_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 512;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PIXELS = 1000;
    localparam int MIN_FRAMES    = 48;
    localparam int WIDE_PHASE    = 2;
    localparam int TALL_PHASE    = 5;
    localparam int NUM_DIRECTED  = 41;

    // One frame result as carried on the master stream.
    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [WIDTH_W-1:0] center;
        logic               stop;
    } frame_result_t;

    typedef enum logic {
        STEP_CFG,
        STEP_PIX
    } step_kind_e;

    // One row of the directed table: a register write or a pixel item.
    typedef struct {
        step_kind_e             kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [WIDTH_W-1:0]     reg_value;
        logic                   pix;
        logic                   fs;
        bit                     typed;
        frame_result_t          typed_res;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [0] pixel_white, [7:1] zero
    logic [0:0]           s_tuser;   // [0] frame_start
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [10:0] lateral_error, [21:11] center_column,
                                     // [22] stop_seen, [23] zero

    lane_center_row_scanner_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor copy of the registers.
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [ROW_W-1:0]    cfg_target_row;
    logic [ROW_W-1:0]    cfg_stop_row;
    logic [COUNT_W-1:0]  cfg_stop_min;

    // Predictor copy of the scan state.
    logic [9:0]          col_cnt;
    logic [ROW_W-1:0]    row_idx;
    logic [WIDTH_W-1:0]  split_col;
    logic [19:0]         left_sum;
    logic [19:0]         right_sum;
    logic [COUNT_W-1:0]  left_cnt;
    logic [COUNT_W-1:0]  right_cnt;
    logic [COUNT_W-1:0]  row_white;
    logic                left_hit;
    logic                right_hit;
    logic [WIDTH_W-1:0]  target_center;
    logic                stop_flag;

    frame_result_t frame_results_q[$];
    step_t         directed_steps [NUM_DIRECTED];
    int            mismatch_count;
    int            cycle_count;
    int            frames_predicted;
    int            pixels_random;
    bit            calm_phase;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(cfg_height);
        if (h < 1) h = 1;
        if (h > MAX_H) h = MAX_H;
        return h;
    endfunction

    function automatic void clear_row();
        col_cnt   = '0;
        left_sum  = '0;
        left_cnt  = '0;
        left_hit  = 1'b0;
        right_sum = '0;
        right_cnt = '0;
        right_hit = 1'b0;
        row_white = '0;
    endfunction

    function automatic void start_frame();
        clear_row();
        row_idx       = '0;
        split_col     = WIDTH_W'(eff_width() / 2);
        target_center = split_col;
    endfunction

    function automatic void reset_predictor();
        cfg_width      = WIDTH_W'(RST_IMAGE_WIDTH);
        cfg_height     = HEIGHT_W'(RST_IMAGE_HEIGHT);
        cfg_target_row = ROW_W'(RST_TARGET_ROW);
        cfg_stop_row   = ROW_W'(RST_STOP_ROW);
        cfg_stop_min   = COUNT_W'(RST_STOP_WHITE_MIN);
        stop_flag      = 1'b0;
        start_frame();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WIDTH_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH:
            begin
                // A new width recenters the split and the target center.
                cfg_width     = val;
                split_col     = WIDTH_W'(eff_width() / 2);
                target_center = split_col;
            end
            CFG_IMAGE_HEIGHT:   cfg_height     = val[HEIGHT_W-1:0];
            CFG_TARGET_ROW:     cfg_target_row = val[ROW_W-1:0];
            CFG_STOP_ROW:       cfg_stop_row   = val[ROW_W-1:0];
            CFG_STOP_WHITE_MIN: cfg_stop_min   = val;
            default: ;
        endcase
    endfunction

    // Advances the scan by one pixel; returns 1 when the pixel closes a frame.
    function automatic bit scan_pixel(input logic pix, input logic fs,
                                      output frame_result_t res);
        int w, h, hw, x, sp, lo, hi, left_edge, right_edge, mid, ri, y;
        res = '0;
        if (fs) start_frame();
        w  = eff_width();
        h  = eff_height();
        hw = w / 2;
        sp = int'(split_col);

        // A column counter beyond a shrunk width lands on the last column.
        x = int'(col_cnt);
        if (x > w - 1) x = w - 1;

        if (pix)
        begin
            row_white = row_white + 1'b1;
            if (x < sp)
            begin
                left_sum = left_sum + 20'(x);
                left_cnt = left_cnt + 1'b1;
                if (x + hw >= sp) left_hit = 1'b1;
            end
            else
            begin
                right_sum = right_sum + 20'(x);
                right_cnt = right_cnt + 1'b1;
                if (x < sp + hw) right_hit = 1'b1;
            end
        end

        if (x + 1 < w)
        begin
            col_cnt = 10'(x + 1);
            return 1'b0;
        end

        // Row end: edges fall back to the window bounds when the window is empty.
        lo = (sp > hw) ? sp - hw : 0;
        hi = (sp + hw < w) ? sp + hw : w;
        left_edge  = (left_hit && left_cnt != 0) ? int'(left_sum) / int'(left_cnt) : lo;
        right_edge = (right_hit && right_cnt != 0) ? int'(right_sum) / int'(right_cnt) : hi;
        mid = (left_edge + right_edge) / 2;
        if (mid > w - 1) mid = w - 1;

        // Rows come bottom first, so the row number counts down to the top row.
        ri = int'(row_idx);
        y  = (ri < h - 1) ? (h - 1) - ri : 0;

        if (y == int'(cfg_stop_row) && row_white >= cfg_stop_min) stop_flag = 1'b1;
        if (y == int'(cfg_target_row)) target_center = WIDTH_W'(mid);
        split_col = WIDTH_W'(mid);
        clear_row();

        if (y != 0)
        begin
            row_idx = row_idx + 1'b1;
            return 1'b0;
        end

        res.err    = ERR_W'(hw - int'(target_center));
        res.center = target_center;
        res.stop   = stop_flag;
        start_frame();
        return 1'b1;
    endfunction

    // Directed table constructors.
    function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx, input int val);
        step_t s;
        s.kind      = STEP_CFG;
        s.reg_index = idx;
        s.reg_value = WIDTH_W'(val);
        s.pix       = 1'b0;
        s.fs        = 1'b0;
        s.typed     = 1'b0;
        s.typed_res = '0;
        return s;
    endfunction

    function automatic step_t pix_step(input int pix, input int fs);
        step_t s;
        s.kind      = STEP_PIX;
        s.reg_index = '0;
        s.reg_value = '0;
        s.pix       = 1'(pix);
        s.fs        = 1'(fs);
        s.typed     = 1'b0;
        s.typed_res = '0;
        return s;
    endfunction

    function automatic step_t frame_end_step(input int pix, input int fs, input int err,
                                             input int center, input int stop);
        step_t s;
        s                  = pix_step(pix, fs);
        s.typed            = 1'b1;
        s.typed_res.err    = ERR_W'(err);
        s.typed_res.center = WIDTH_W'(center);
        s.typed_res.stop   = 1'(stop);
        return s;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one pixel item and records the frame result it closes, if any.
    task automatic send_pixel(input logic pix, input logic fs, input bit typed,
                              input frame_result_t typed_res);
        frame_result_t res;
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pix};
        s_tuser  <= fs;
        do @(posedge clk); while (!s_tready);
        if (scan_pixel(pix, fs, res))
        begin
            frame_results_q.push_back(typed ? typed_res : res);
            frames_predicted++;
        end
    endtask

    // Waits until every frame result is out and any row-end work has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= WIDTH_W'(val);
        @(posedge clk);
        apply_reg(idx, WIDTH_W'(val));
    endtask

    // One random setting followed by a few frames, mostly well formed.
    task automatic run_random_phase(input int phase);
        int wr, hr, ew, eh, tr, sr, sm, density, frames, kind, n, cut, restart, r;
        logic fs;
        r = $urandom_range(0, 99);
        if (r < 5) wr = $urandom_range(0, 1);
        else if (r < 15) wr = $urandom_range(13, 40);
        else wr = $urandom_range(2, 12);
        hr = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        ew = (wr < 2) ? 2 : wr;
        eh = (hr < 1) ? 1 : hr;
        tr = ($urandom_range(0, 6) == 0) ? $urandom_range(eh, 511) : $urandom_range(0, eh - 1);
        sr = ($urandom_range(0, 6) == 0) ? $urandom_range(eh, 511) : $urandom_range(0, eh - 1);
        sm = ($urandom_range(0, 9) == 0) ? $urandom_range(ew + 1, 2047) : $urandom_range(0, ew);
        density = $urandom_range(0, 100);
        frames = $urandom_range(1, 4);

        // Largest width on a single row, and tallest frame on the narrowest width.
        if (phase == WIDE_PHASE)
        begin
            wr = 2047; hr = 1; ew = MAX_W; eh = 1;
            tr = 0; sr = 0; sm = 2047; frames = 1;
        end
        else if (phase == TALL_PHASE)
        begin
            wr = 1; hr = 1023; ew = 2; eh = MAX_H;
            tr = 511; sr = 511; sm = 0; frames = 1;
        end

        calm_phase = ($urandom_range(0, 3) == 0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, wr);
        write_reg(CFG_IMAGE_HEIGHT, hr);
        write_reg(CFG_TARGET_ROW, tr);
        write_reg(CFG_STOP_ROW, sr);
        write_reg(CFG_STOP_WHITE_MIN, sm);
        cfg_we <= 1'b0;

        for (int f = 0; f < frames; f++)
        begin
            // Kinds: cut short, restarted inside, no frame start, or well formed.
            kind = (phase == WIDE_PHASE || phase == TALL_PHASE) ? 9 : $urandom_range(0, 9);
            n = ew * eh;
            cut = (kind == 0) ? $urandom_range(1, n) : n;
            restart = (kind == 1) ? $urandom_range(1, n - 1) : -1;
            for (int i = 0; i < cut; i++)
            begin
                fs = (i == 0 && kind != 2) || (i == restart);
                send_pixel($urandom_range(0, 99) < density, fs, 1'b0, '0);
                pixels_random++;
            end
        end
    endtask

    // Sink pacing: long ready stretches mixed with short and long stalls.
    initial
    begin : sink_pacing
        int r, stall, run;
        m_tready <= 1'b0;
        repeat (8) @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            stall = (r < 40) ? 0 : ((r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40));
            run = $urandom_range(1, (r < 40) ? 64 : 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    // Compare each frame result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_q.size() == 0)
            begin
                $display("%0t: result with none pending, expected nothing, got %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (m_tdata[10:0] !== want.err)
                begin
                    $display("%0t: lateral_error expected %0d, got %0d", $time,
                             $signed(want.err), $signed(m_tdata[10:0]));
                    mismatch_count++;
                end
                if (m_tdata[21:11] !== want.center)
                begin
                    $display("%0t: center_column expected %0d, got %0d", $time,
                             want.center, m_tdata[21:11]);
                    mismatch_count++;
                end
                if (m_tdata[22] !== want.stop)
                begin
                    $display("%0t: stop_seen expected %0b, got %0b", $time,
                             want.stop, m_tdata[22]);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random phases.
    initial
    begin : stimulus
        int phase;
        bit in_cfg;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        reset_predictor();

        directed_steps = '{
            // Two-column single-row frames; results come from the window bounds and the side means.
            cfg_step(CFG_IMAGE_WIDTH, 2),
            cfg_step(CFG_IMAGE_HEIGHT, 1),
            cfg_step(CFG_TARGET_ROW, 0),
            cfg_step(CFG_STOP_ROW, 0),
            cfg_step(CFG_STOP_WHITE_MIN, 3),
            pix_step(0, 1),
            frame_end_step(0, 0, 0, 1, 0),
            pix_step(1, 1),
            frame_end_step(1, 0, 1, 0, 0),
            pix_step(0, 1),
            frame_end_step(1, 0, 1, 0, 0),
            // Frame start in the middle of a row restarts the row.
            pix_step(1, 1),
            pix_step(0, 1),
            pix_step(1, 0),
            // Width below range clamps; target row outside the frame gives the half width.
            cfg_step(CFG_IMAGE_WIDTH, 0),
            cfg_step(CFG_IMAGE_HEIGHT, 3),
            cfg_step(CFG_TARGET_ROW, 7),
            cfg_step(CFG_STOP_ROW, 1),
            cfg_step(CFG_STOP_WHITE_MIN, 2),
            pix_step(1, 1),
            pix_step(1, 0),
            pix_step(1, 0),
            pix_step(0, 0),
            pix_step(1, 0),
            frame_end_step(1, 0, 0, 1, 0),
            // Width shrunk in mid row ends the row, height shrunk ends the frame.
            cfg_step(CFG_IMAGE_WIDTH, 8),
            cfg_step(CFG_IMAGE_HEIGHT, 4),
            cfg_step(CFG_TARGET_ROW, 3),
            cfg_step(CFG_STOP_ROW, 0),
            cfg_step(CFG_STOP_WHITE_MIN, 5),
            pix_step(1, 1),
            pix_step(0, 0),
            pix_step(1, 0),
            pix_step(0, 0),
            cfg_step(CFG_IMAGE_WIDTH, 4),
            pix_step(1, 0),
            cfg_step(CFG_IMAGE_HEIGHT, 1),
            pix_step(1, 0),
            pix_step(1, 0),
            pix_step(1, 0),
            pix_step(1, 0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        calm_phase = 1'b0;
        in_cfg = 1'b0;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CFG)
            begin
                if (!in_cfg) settle();
                write_reg(directed_steps[i].reg_index, int'(directed_steps[i].reg_value));
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg) cfg_we <= 1'b0;
                in_cfg = 1'b0;
                send_pixel(directed_steps[i].pix, directed_steps[i].fs,
                           directed_steps[i].typed, directed_steps[i].typed_res);
            end
        end

        phase = 0;
        while (pixels_random < RANDOM_PIXELS || frames_predicted < MIN_FRAMES)
        begin
            run_random_phase(phase);
            phase++;
        end

        // Drain and give any stray result time to show up.
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
